/* sv/rpsc_pkg.sv */
// shared types, register codes and constants of the ramped pi speed controller
package rpsc_pkg;

	localparam int CFG_DATA_W = 24;
	localparam int REG_IDX_W  = 3;
	localparam int COEF_W     = 24;
	localparam int RPM_W      = 16;
	localparam int MEAS_W     = 18;
	localparam int ERR_W      = 20;
	localparam int DRIVE_W    = 15;
	localparam int ACC_W      = 32;
	localparam int IN_DATA_W  = 32;
	localparam int IN_USER_W  = 1;
	localparam int OUT_DATA_W = 56;
	localparam int OUT_USER_W = 2;

	// digit-serial multiplier: radix 16, coefficient widened to 25 bits signed
	localparam int DIG_W      = 4;
	localparam int MUL_B_W    = COEF_W + 1;
	localparam int MUL_DIGITS = (MUL_B_W + DIG_W - 1) / DIG_W;
	localparam int MUL_LO_W   = MUL_DIGITS * DIG_W;

	localparam longint DRIVE_LIMIT = 64'd655360000;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_SPEED_SCALE   = 3'd0,
		REG_COEF_NOW      = 3'd1,
		REG_COEF_PREV     = 3'd2,
		REG_TARGET_RPM    = 3'd3,
		REG_STEP_RPM      = 3'd4,
		REG_STEP_TICKS    = 3'd5,
		REG_OVERSPEED_RPM = 3'd6,
		REG_RAMP_DOWN     = 3'd7
	} rpsc_reg_t;

	typedef struct packed {
		logic        [COEF_W-1:0] speed_scale;
		logic signed [COEF_W-1:0] coef_now;
		logic signed [COEF_W-1:0] coef_prev;
		logic        [RPM_W-1:0]  target_rpm;
		logic        [RPM_W-1:0]  step_rpm;
		logic        [RPM_W-1:0]  step_ticks;
		logic        [RPM_W-1:0]  overspeed_rpm;
		logic        [RPM_W-1:0]  ramp_down_step;
	} rpsc_cfg_t;

	localparam rpsc_cfg_t CFG_RESET = '{
		speed_scale:    24'd551800,
		coef_now:       24'sd275251,
		coef_prev:      -24'sd274993,
		target_rpm:     16'd0,
		step_rpm:       16'd0,
		step_ticks:     16'd200,
		overspeed_rpm:  16'd51200,
		ramp_down_step: 16'd26
	};

	typedef struct packed {
		logic             running;
		logic             tripped;
		logic [RPM_W-1:0] ref_rpm;
	} rpsc_ramp_t;

endpackage

/* sv/rpsc_dmul.sv */
// radix-16 digit-serial signed multiplier, one coefficient digit per cycle
module rpsc_dmul #(
	parameter int A_W = 32
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          start,
	input  logic signed [A_W-1:0]                         a,
	input  logic signed [rpsc_pkg::MUL_B_W-1:0]           b,
	output logic                                          done,
	output logic signed [A_W+2+rpsc_pkg::MUL_LO_W-1:0]    prod
);
	import rpsc_pkg::*;

	localparam int CNT_W = $clog2(MUL_DIGITS);
	localparam int PART_W = A_W + 2;
	localparam int PP_W = A_W + 5;
	localparam int SUM_W = A_W + 6;

	logic signed [A_W-1:0]    a_q;
	logic [MUL_LO_W-1:0]      b_q;
	logic [PART_W-1:0]        part_q;
	logic [MUL_LO_W-1:0]      lo_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     busy_q;
	logic                     done_q;

	logic [DIG_W-1:0]         dig;
	logic                     last_dig;
	logic signed [DIG_W:0]    sdig;
	logic signed [PP_W-1:0]   pp;
	logic [SUM_W-1:0]         sum;

	assign dig = b_q[DIG_W-1:0];
	assign last_dig = (cnt_q == CNT_W'(MUL_DIGITS - 1));
	// top digit carries the sign of the coefficient
	assign sdig = last_dig ? {dig[DIG_W-1], dig} : {1'b0, dig};
	assign pp = a_q * sdig;
	assign sum = {{(SUM_W-PART_W){part_q[PART_W-1]}}, part_q} + {pp[PP_W-1], pp};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (last_dig) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= {{(MUL_LO_W-MUL_B_W){b[MUL_B_W-1]}}, b};
			part_q <= '0;
		end else if (busy_q) begin
			b_q <= {{DIG_W{1'b0}}, b_q[MUL_LO_W-1:DIG_W]};
			lo_q <= {sum[DIG_W-1:0], lo_q[MUL_LO_W-1:DIG_W]};
			part_q <= sum[SUM_W-1:DIG_W];
		end
	end

	assign done = done_q;
	assign prod = {part_q, lo_q};

endmodule

/* sv/rpsc_ramp.sv */
// trip latch, step counter and ramped reference speed
module rpsc_ramp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                upd,
	input  logic                                run,
	input  logic signed [rpsc_pkg::MEAS_W-1:0]  measured,
	input  rpsc_pkg::rpsc_cfg_t                 cfg,
	output rpsc_pkg::rpsc_ramp_t                status
);
	import rpsc_pkg::*;

	logic [RPM_W-1:0] ref_q;
	logic [RPM_W-1:0] tick_q;
	logic             trip_q;
	logic             running_q;

	logic             trip_nx;
	logic             run_nx;
	logic [RPM_W-1:0] tick_inc;
	logic             step_due;
	logic [RPM_W:0]   rise;
	logic [RPM_W-1:0] up_ref;
	logic [RPM_W-1:0] down_ref;

	assign trip_nx = run &&
		(trip_q || (measured > $signed({2'b00, cfg.overspeed_rpm})));
	assign run_nx = run && !trip_nx;
	assign tick_inc = tick_q + RPM_W'(1);
	assign step_due = (tick_inc >= cfg.step_ticks);
	assign rise = {1'b0, ref_q} + {1'b0, cfg.step_rpm};

	always_comb begin
		if (rise < {1'b0, cfg.target_rpm}) begin
			up_ref = rise[RPM_W-1:0];
		end else if (ref_q < cfg.target_rpm) begin
			up_ref = cfg.target_rpm;
		end else begin
			up_ref = ref_q;
		end
		if (ref_q > cfg.ramp_down_step) begin
			down_ref = ref_q - cfg.ramp_down_step;
		end else begin
			down_ref = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q <= '0;
			tick_q <= '0;
			trip_q <= 1'b0;
			running_q <= 1'b0;
		end else if (upd) begin
			trip_q <= trip_nx;
			running_q <= run_nx;
			if (run_nx) begin
				// counter wraps whenever it reaches the step interval
				tick_q <= step_due ? '0 : tick_inc;
				if (step_due) begin
					ref_q <= up_ref;
				end
			end else begin
				ref_q <= down_ref;
			end
		end
	end

	assign status = '{running: running_q, tripped: trip_q, ref_rpm: ref_q};

endmodule

/* sv/ramped_pi_speed_controller.sv */
// One word in, one word out: each tick's encoder count and run request give the measured
// speed, the ramped reference, the PI drive voltage and the run/trip flags. The next item
// is taken once the result of the last one is loaded into the output register; the pace is
// set by the single shared radix-16 digit-serial multiplier, which makes three passes per
// item (speed scaling, gain on current error, gain on previous error), one coefficient digit
// at a time. A result waiting at the output does not stop the next item from being
// accepted; that item only waits at its last step until the output register is free.
module ramped_pi_speed_controller #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [rpsc_pkg::IN_DATA_W-1:0]       s_tdata,   // encoder_count
	input  logic [rpsc_pkg::IN_USER_W-1:0]       s_tuser,   // run_request
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [rpsc_pkg::OUT_DATA_W-1:0]      m_tdata,   // measured_rpm, reference_rpm, drive_mv
	output logic [rpsc_pkg::OUT_USER_W-1:0]      m_tuser,   // running, tripped
	input  logic                                 cfg_wr_en,
	input  logic [rpsc_pkg::REG_IDX_W-1:0]       cfg_addr,
	input  logic [rpsc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
	import rpsc_pkg::*;

	localparam int A_W = (COUNT_WIDTH > ERR_W) ? COUNT_WIDTH : ERR_W;
	localparam int PROD_W = A_W + 2 + MUL_LO_W;
	localparam logic signed [PROD_W-1:0] MEAS_HI = PROD_W'(131071);
	localparam logic signed [PROD_W-1:0] MEAS_LO = PROD_W'(-131072);
	localparam logic signed [PROD_W:0] DRV_HI = (PROD_W+1)'(DRIVE_LIMIT);
	localparam logic signed [PROD_W:0] DRV_LO = -(PROD_W+1)'(DRIVE_LIMIT);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MEAS,
		ST_RAMP,
		ST_ERR,
		ST_MUL2,
		ST_MUL3,
		ST_ACC,
		ST_OUT
	} state_t;

	state_t                        st_q;
	rpsc_cfg_t                     cfg_q;
	logic [COUNT_WIDTH-1:0]        last_q;
	logic                          seen_q;
	logic                          run_q;
	logic signed [MEAS_W-1:0]      meas_q;
	logic signed [ERR_W-1:0]       err_q;
	logic signed [ERR_W-1:0]       err_prev_q;
	logic signed [PROD_W-1:0]      p2_q;
	logic signed [PROD_W:0]        sum_q;
	logic signed [ACC_W-1:0]       drive_q;
	logic                          m_tvalid_q;
	logic [OUT_DATA_W-1:0]         m_tdata_q;
	logic [OUT_USER_W-1:0]         m_tuser_q;

	logic                          accept;
	logic [COUNT_WIDTH-1:0]        diff_raw;
	logic signed [COUNT_WIDTH-1:0] diff;
	logic signed [ERR_W-1:0]       err_nx;
	logic                          mul_start;
	logic signed [A_W-1:0]         mul_a;
	logic signed [MUL_B_W-1:0]     mul_b;
	logic                          mul_done;
	logic signed [PROD_W-1:0]      prod;
	logic signed [PROD_W-1:0]      meas_t;
	logic signed [PROD_W-1:0]      meas_sh;
	logic signed [MEAS_W-1:0]      meas_sat;
	logic signed [PROD_W:0]        psum_t;
	logic signed [PROD_W:0]        acc_t;
	logic signed [ACC_W-1:0]       acc_sat;
	logic signed [ACC_W:0]         drv_t;
	logic signed [ACC_W:0]         drv_sh;
	rpsc_ramp_t                    ramp;

	assign s_tready = (st_q == ST_IDLE);
	assign accept = s_tvalid && s_tready;

	// count difference, zero on the first tick
	assign diff_raw = s_tdata[COUNT_WIDTH-1:0] - last_q;
	assign diff = seen_q ? diff_raw : '0;
	assign err_nx = $signed({4'b0000, ramp.ref_rpm}) - ERR_W'(meas_q);

	assign mul_start = accept || (st_q == ST_ERR) || ((st_q == ST_MUL2) && mul_done);

	always_comb begin
		unique case (st_q)
			ST_IDLE: begin
				mul_a = A_W'(diff);
				mul_b = {1'b0, cfg_q.speed_scale};
			end
			ST_ERR: begin
				mul_a = A_W'(err_nx);
				mul_b = {cfg_q.coef_now[COEF_W-1], cfg_q.coef_now};
			end
			ST_MUL2: begin
				mul_a = A_W'(err_prev_q);
				mul_b = {cfg_q.coef_prev[COEF_W-1], cfg_q.coef_prev};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	rpsc_dmul #(
		.A_W(A_W)
	) u_dmul (
		.clk(clk),
		.arst_n(arst_n),
		.start(mul_start),
		.a(mul_a),
		.b(mul_b),
		.done(mul_done),
		.prod(prod)
	);

	rpsc_ramp u_ramp (
		.clk(clk),
		.arst_n(arst_n),
		.upd(st_q == ST_RAMP),
		.run(run_q),
		.measured(meas_q),
		.cfg(cfg_q),
		.status(ramp)
	);

	// rpm q16 to q8 with round half up, then saturate
	assign meas_t = prod + PROD_W'(128);
	assign meas_sh = meas_t >>> 8;

	always_comb begin
		if (meas_sh > MEAS_HI) begin
			meas_sat = MEAS_W'(MEAS_HI);
		end else if (meas_sh < MEAS_LO) begin
			meas_sat = MEAS_W'(MEAS_LO);
		end else begin
			meas_sat = meas_sh[MEAS_W-1:0];
		end
	end

	assign psum_t = (PROD_W+1)'(p2_q) + (PROD_W+1)'(prod) + (PROD_W+1)'(128);
	assign acc_t = (PROD_W+1)'(drive_q) + sum_q;

	always_comb begin
		if (acc_t > DRV_HI) begin
			acc_sat = ACC_W'(DRV_HI);
		end else if (acc_t < DRV_LO) begin
			acc_sat = ACC_W'(DRV_LO);
		end else begin
			acc_sat = acc_t[ACC_W-1:0];
		end
	end

	assign drv_t = (ACC_W+1)'(drive_q) + (ACC_W+1)'(32768);
	assign drv_sh = drv_t >>> 16;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_wr_en) begin
			unique case (rpsc_reg_t'(cfg_addr))
				REG_SPEED_SCALE:   cfg_q.speed_scale <= cfg_wdata;
				REG_COEF_NOW:      cfg_q.coef_now <= cfg_wdata;
				REG_COEF_PREV:     cfg_q.coef_prev <= cfg_wdata;
				REG_TARGET_RPM:    cfg_q.target_rpm <= cfg_wdata[RPM_W-1:0];
				REG_STEP_RPM:      cfg_q.step_rpm <= cfg_wdata[RPM_W-1:0];
				REG_STEP_TICKS:    cfg_q.step_ticks <= cfg_wdata[RPM_W-1:0];
				REG_OVERSPEED_RPM: cfg_q.overspeed_rpm <= cfg_wdata[RPM_W-1:0];
				REG_RAMP_DOWN:     cfg_q.ramp_down_step <= cfg_wdata[RPM_W-1:0];
				default: ;
			endcase
		end
	end

	// controller state kept across ticks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
			seen_q <= 1'b0;
			err_prev_q <= '0;
			drive_q <= '0;
		end else begin
			if (accept) begin
				last_q <= s_tdata[COUNT_WIDTH-1:0];
				seen_q <= 1'b1;
			end
			if (st_q == ST_ACC) begin
				drive_q <= acc_sat;
				err_prev_q <= err_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			run_q <= s_tuser[0];
		end
		if ((st_q == ST_MEAS) && mul_done) begin
			meas_q <= meas_sat;
		end
		if (st_q == ST_ERR) begin
			err_q <= err_nx;
		end
		if ((st_q == ST_MUL2) && mul_done) begin
			p2_q <= prod;
		end
		if ((st_q == ST_MUL3) && mul_done) begin
			sum_q <= psum_t >>> 8;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			m_tvalid_q <= 1'b0;
			m_tdata_q <= '0;
			m_tuser_q <= '0;
		end else begin
			// in the output step a taken word is replaced by the new one below
			if (m_tvalid_q && m_tready && (st_q != ST_OUT)) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (accept) begin
						st_q <= ST_MEAS;
					end
				end
				ST_MEAS: begin
					if (mul_done) begin
						st_q <= ST_RAMP;
					end
				end
				ST_RAMP: st_q <= ST_ERR;
				ST_ERR:  st_q <= ST_MUL2;
				ST_MUL2: begin
					if (mul_done) begin
						st_q <= ST_MUL3;
					end
				end
				ST_MUL3: begin
					if (mul_done) begin
						st_q <= ST_ACC;
					end
				end
				ST_ACC:  st_q <= ST_OUT;
				ST_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q <= {{(OUT_DATA_W-MEAS_W-RPM_W-DRIVE_W){1'b0}},
							drv_sh[DRIVE_W-1:0], ramp.ref_rpm, meas_q};
						m_tuser_q <= {ramp.tripped, ramp.running};
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tuser = m_tuser_q;

endmodule

/* sv/rpsc_checker.sv */
// port-level checks of the ramped pi speed controller and their binding
module rpsc_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [rpsc_pkg::OUT_DATA_W-1:0]   m_tdata,
	input logic [rpsc_pkg::OUT_USER_W-1:0]   m_tuser
);
	import rpsc_pkg::*;

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	// one tick in flight at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second word taken while a tick is in flight");

	// a tripped drive never reports running
	a_trip_stop: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("running and tripped together");

	// drive voltage stays within the rail limits
	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[48:34]) <= 15'sd10000)
			&& ($signed(m_tdata[48:34]) >= -15'sd10000))
		else $error("drive voltage out of range");

endmodule

bind ramped_pi_speed_controller rpsc_checker u_rpsc_checker (.*);
